### sv/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and helpers for the utf-8 stream decoder
// Word formats on both ports, the classified word passed from front to back,
// status codes and the lead byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LEAD  = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_e;

  // sequence lengths given by a lead byte
  localparam logic [2:0] LenInvalid = 3'd0;
  localparam logic [2:0] LenOne     = 3'd1;
  localparam logic [2:0] LenTwo     = 3'd2;
  localparam logic [2:0] LenThree   = 3'd3;
  localparam logic [2:0] LenFour    = 3'd4;
  localparam logic [2:0] LenFive    = 3'd5;
  localparam logic [2:0] LenSix     = 3'd6;

  // input word
  typedef struct packed {
    logic [7:0] byte_value;
    logic       string_end;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        last_of_string;
  } out_word_t;

  // byte after classification by the front
  typedef struct packed {
    logic [7:0] byte_value;
    logic       string_end;
    logic [2:0] lead_len;
    logic [4:0] lead_bits;
  } cls_word_t;

  // sequence length implied by a lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    unique case (b) inside
      [8'h00:8'h7F]: len = LenOne;
      [8'h80:8'hBF]: len = LenInvalid;
      [8'hC0:8'hDF]: len = LenTwo;
      [8'hE0:8'hEF]: len = LenThree;
      [8'hF0:8'hF7]: len = LenFour;
      [8'hF8:8'hFB]: len = LenFive;
      [8'hFC:8'hFD]: len = LenSix;
      default:       len = LenInvalid;
    endcase
    return len;
  endfunction

  // payload bits a lead byte keeps for its sequence length
  function automatic logic [4:0] lead_payload(input logic [7:0] b, input logic [2:0] len);
    logic [4:0] bits;
    unique case (len)
      LenTwo:   bits = b[4:0];
      LenThree: bits = {1'b0, b[3:0]};
      LenFour:  bits = {2'b00, b[2:0]};
      LenFive:  bits = {3'b000, b[1:0]};
      LenSix:   bits = {4'b0000, b[0]};
      default:  bits = 5'd0;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

### sv/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front: input side of the decoder
// Takes one byte word a cycle while the queue is not full, decodes its lead
// length and lead payload bits and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_front (
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  u8sd_pkg::in_word_t    in_word_i,
  input  wire                   q_full_i,
  output logic                  q_push_o,
  output u8sd_pkg::cls_word_t   q_word_o
);

  logic [2:0] len;

  // lead decode
  always_comb begin
    len                 = u8sd_pkg::lead_length(in_word_i.byte_value);
    q_word_o.byte_value = in_word_i.byte_value;
    q_word_o.string_end = in_word_i.string_end;
    q_word_o.lead_len   = len;
    q_word_o.lead_bits  = u8sd_pkg::lead_payload(in_word_i.byte_value, len);
  end

  // handshake: stall only on a full queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule

`default_nettype wire

### sv/u8sd_queue.sv
// ----------------------------------------------------------------------------
// u8sd_queue: small word queue between front and back
// Registered entries with read and write pointers and a fill count; the
// full flag comes from the count register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  u8sd_pkg::cls_word_t   push_word_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  head_valid_o,
  output u8sd_pkg::cls_word_t   head_word_o
);

  localparam int unsigned Aw = u8sd_pkg::QueueAw;
  localparam logic [Aw:0] DepthCount = (Aw + 1)'(u8sd_pkg::QueueDepth);
  localparam logic [Aw-1:0] LastPtr = Aw'(u8sd_pkg::QueueDepth - 1);

  u8sd_pkg::cls_word_t entry_q [u8sd_pkg::QueueDepth];
  logic [Aw-1:0] wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0] rd_ptr_q, rd_ptr_d;
  logic [Aw:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign full_o       = (count_q == DepthCount);
  assign head_valid_o = (count_q != '0);
  assign head_word_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_word_i;
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCount)
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

### sv/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back: sequence state and result register
// Pops classified words, gathers continuation bits into the pending code
// point, handles bad lead, truncation and discard, and holds each result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   head_valid_i,
  input  u8sd_pkg::cls_word_t   head_word_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output u8sd_pkg::out_word_t   out_word_o
);

  logic [2:0]          exp_len_q, exp_len_d;
  logic [2:0]          taken_q, taken_d;
  logic [30:0]         partial_q, partial_d;
  logic                discard_q, discard_d;
  logic                out_valid_q, out_valid_d;
  u8sd_pkg::out_word_t out_word_q, out_word_d;

  logic                has_result;
  u8sd_pkg::out_word_t result;
  logic [30:0]         shifted;
  logic [2:0]          taken_inc;
  logic                b_end;

  // pop when the output register is free or emptying this cycle
  assign pop_o = head_valid_i & (~out_valid_q | ~out_stall_i);

  assign b_end     = head_word_i.string_end;
  assign shifted   = {partial_q[24:0], head_word_i.byte_value[5:0]};
  assign taken_inc = taken_q + 3'd1;

  // per-word sequence update
  always_comb begin
    exp_len_d  = exp_len_q;
    taken_d    = taken_q;
    partial_d  = partial_q;
    discard_d  = discard_q;
    has_result = 1'b0;
    result     = '{code_point: '0, status: u8sd_pkg::STATUS_OK, last_of_string: b_end};
    if (discard_q) begin
      // dropping the rest of a failed string
      if (b_end) begin
        discard_d = 1'b0;
      end
      exp_len_d = '0;
      taken_d   = '0;
      partial_d = '0;
    end else if (exp_len_q == '0) begin
      // lead position
      if (head_word_i.lead_len == u8sd_pkg::LenInvalid) begin
        has_result    = 1'b1;
        result.status = u8sd_pkg::STATUS_BAD_LEAD;
        discard_d     = ~b_end;
      end else if (head_word_i.lead_len == u8sd_pkg::LenOne) begin
        has_result        = 1'b1;
        result.code_point = {23'd0, head_word_i.byte_value};
      end else if (b_end) begin
        has_result    = 1'b1;
        result.status = u8sd_pkg::STATUS_TRUNCATED;
      end else begin
        exp_len_d = head_word_i.lead_len;
        taken_d   = 3'd1;
        partial_d = {26'd0, head_word_i.lead_bits};
      end
    end else begin
      // continuation position
      if (taken_inc >= exp_len_q) begin
        has_result        = 1'b1;
        result.code_point = shifted;
        exp_len_d         = '0;
        taken_d           = '0;
        partial_d         = '0;
      end else if (b_end) begin
        has_result    = 1'b1;
        result.status = u8sd_pkg::STATUS_TRUNCATED;
        exp_len_d     = '0;
        taken_d       = '0;
        partial_d     = '0;
      end else begin
        taken_d   = taken_inc;
        partial_d = shifted;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && has_result) begin
      out_valid_d = 1'b1;
      out_word_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q   <= '0;
      taken_q     <= '0;
      partial_q   <= '0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        exp_len_q <= exp_len_d;
        taken_q   <= taken_d;
        partial_q <= partial_d;
        discard_q <= discard_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a pending sequence is never complete
  a_taken_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_len_q != '0) |-> (taken_q < exp_len_q && taken_q != '0))
    else $error("pending sequence count out of range");

  // no sequence is pending while discarding
  a_discard_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> (exp_len_q == '0))
    else $error("sequence pending while discarding");

  // error results carry a zero code point
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.status != u8sd_pkg::STATUS_OK) |-> (out_word_q.code_point == '0))
    else $error("error result with nonzero code point");

endmodule

`default_nettype wire

### sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder: utf-8 decoder for the original 1 to 6 byte form
// Byte words in, code point words out, decoupled by a short queue.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle and returns at most one result word per
// byte; with no stall on the output it sustains one byte per cycle. A byte
// passes the lead decoder in the front, is written into a four-entry queue,
// and is decoded into the result register at the edge that pops it. The
// lead byte alone sets the sequence length; continuation bytes are not
// checked. After an invalid lead the rest of the string up to its last
// byte is dropped without results. A stalled output fills the queue and
// then stalls the input.
`default_nettype none

module utf8_stream_decoder (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  u8sd_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output u8sd_pkg::out_word_t  out_word_o
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_head_valid;
  u8sd_pkg::cls_word_t q_push_word;
  u8sd_pkg::cls_word_t q_head_word;

  // classify incoming bytes
  u8sd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (q_push_word)
  );

  // decoupling queue
  u8sd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_word_i  (q_push_word),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_word_o  (q_head_word)
  );

  // sequence decode and result register
  u8sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_word_i  (q_head_word),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the utf-8 stream decoder
// Feeds byte words (directed corner cases, then random strings made mostly of
// well-formed sequences with some noise), decodes each accepted byte in a
// local model and compares every result word field by field, with random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned ItemTarget  = 1050;
  localparam int unsigned MaxGap      = 19;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports  = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  u8sd_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  u8sd_pkg::out_word_t out_word_o;

  utf8_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // byte words waiting to be sent and result words still owed by the block
  u8sd_pkg::in_word_t  pending_bytes[$];
  u8sd_pkg::out_word_t owed_words[$];

  // decoder model state
  logic [2:0]  seq_len;
  logic [2:0]  seq_count;
  logic [30:0] seq_bits;
  logic        dropping;

  int unsigned total_bytes;
  int unsigned bytes_sent;
  int unsigned words_seen;
  int unsigned ok_seen;
  int unsigned bad_lead_seen;
  int unsigned truncated_seen;
  int unsigned mismatches;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          in_burst;
  bit          out_burst;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sequence length a byte gives in lead position, zero for an invalid lead
  function automatic logic [2:0] seq_length_of(input logic [7:0] b);
    if (b < 8'h80) return u8sd_pkg::LenOne;
    if (b < 8'hC0) return u8sd_pkg::LenInvalid;
    if (b < 8'hE0) return u8sd_pkg::LenTwo;
    if (b < 8'hF0) return u8sd_pkg::LenThree;
    if (b < 8'hF8) return u8sd_pkg::LenFour;
    if (b < 8'hFC) return u8sd_pkg::LenFive;
    if (b < 8'hFE) return u8sd_pkg::LenSix;
    return u8sd_pkg::LenInvalid;
  endfunction

  function automatic u8sd_pkg::out_word_t make_word(input logic [30:0] cp,
                                                    input u8sd_pkg::status_e st,
                                                    input logic last);
    u8sd_pkg::out_word_t w;
    w.code_point     = cp;
    w.status         = st;
    w.last_of_string = last;
    return w;
  endfunction

  task automatic clear_seq();
    seq_len   = u8sd_pkg::LenInvalid;
    seq_count = 3'd0;
    seq_bits  = '0;
  endtask

  // decode one accepted byte word and queue the result it causes, if any
  task automatic decode_byte(input u8sd_pkg::in_word_t w);
    logic [2:0] len;
    if (dropping) begin
      if (w.string_end) dropping = 1'b0;
      clear_seq();
    end else if (seq_len == u8sd_pkg::LenInvalid) begin
      len = seq_length_of(w.byte_value);
      if (len == u8sd_pkg::LenInvalid) begin
        clear_seq();
        dropping = !w.string_end;
        owed_words.push_back(make_word('0, u8sd_pkg::STATUS_BAD_LEAD, w.string_end));
      end else if (len == u8sd_pkg::LenOne) begin
        owed_words.push_back(make_word({23'd0, w.byte_value}, u8sd_pkg::STATUS_OK,
                                       w.string_end));
      end else begin
        seq_bits  = {23'd0, w.byte_value & (8'h3F >> (len - 3'd1))};
        seq_len   = len;
        seq_count = 3'd1;
        if (w.string_end) begin
          clear_seq();
          owed_words.push_back(make_word('0, u8sd_pkg::STATUS_TRUNCATED, 1'b1));
        end
      end
    end else begin
      seq_bits  = {seq_bits[24:0], w.byte_value[5:0]};
      seq_count = seq_count + 3'd1;
      if (seq_count >= seq_len) begin
        owed_words.push_back(make_word(seq_bits, u8sd_pkg::STATUS_OK, w.string_end));
        clear_seq();
      end else if (w.string_end) begin
        clear_seq();
        owed_words.push_back(make_word('0, u8sd_pkg::STATUS_TRUNCATED, 1'b1));
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    u8sd_pkg::in_word_t w;
    w.byte_value = b;
    w.string_end = last;
    pending_bytes.push_back(w);
  endtask

  // random lead byte for a sequence of the given length
  function automatic logic [7:0] rand_lead(input int unsigned len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  // compare one result word with the oldest owed word
  task automatic check_word(input u8sd_pkg::out_word_t got);
    u8sd_pkg::out_word_t want;
    bit                  bad;
    if (owed_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: unexpected result word cp=%h st=%0d last=%0b", $time,
                 got.code_point, got.status, got.last_of_string);
      return;
    end
    want = owed_words.pop_front();
    bad  = (got.code_point !== want.code_point) || (got.status !== want.status) ||
           (got.last_of_string !== want.last_of_string);
    if (bad) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display({"%0t: result %0d mismatch: expected cp=%h st=%0d last=%0b, ",
                  "got cp=%h st=%0d last=%0b"},
                 $time, words_seen, want.code_point, want.status, want.last_of_string,
                 got.code_point, got.status, got.last_of_string);
    end
    case (want.status)
      u8sd_pkg::STATUS_OK:       ok_seen++;
      u8sd_pkg::STATUS_BAD_LEAD: bad_lead_seen++;
      default:                   truncated_seen++;
    endcase
  endtask

  // driver: sends queued byte words with a random gap after each one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_word_i);
        bytes_sent++;
        if (bytes_sent % 100 == 0) in_burst = ($urandom_range(0, 3) == 0);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (pending_bytes.size() > 0) begin
          in_word_i  <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          gap_left   = in_burst ? 0 : $urandom_range(0, MaxGap);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: takes result words and stalls at random after each one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_word(out_word_o);
        words_seen++;
        if (words_seen % 100 == 0) out_burst = ($urandom_range(0, 3) == 0);
        hold_left = out_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned        nchars;
    int unsigned        kind;
    int unsigned        len;
    int unsigned        keep;
    int unsigned        pick;
    u8sd_pkg::in_word_t tail;

    clear_seq();
    dropping       = 1'b0;
    bytes_sent     = 0;
    words_seen     = 0;
    ok_seen        = 0;
    bad_lead_seen  = 0;
    truncated_seen = 0;
    mismatches     = 0;
    gap_left       = 0;
    hold_left      = 0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;

    // smallest and largest one byte characters
    add_byte(8'h00, 1'b1);
    add_byte(8'h7F, 1'b0);
    // largest two byte and six byte characters
    add_byte(8'hDF, 1'b0);
    add_byte(8'hBF, 1'b1);
    add_byte(8'hFD, 1'b0);
    repeat (5) add_byte(8'hBF, 1'b0);
    add_byte(8'h41, 1'b1);
    // continuation byte as lead, rest of the string dropped
    add_byte(8'h80, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'h41, 1'b1);
    // invalid lead on the last byte, no dropping after it
    add_byte(8'hFE, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h41, 1'b1);
    // string ends on a lead byte, then inside a three byte sequence
    add_byte(8'hC3, 1'b1);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b1);
    // lead-like byte inside a sequence counts as continuation
    add_byte(8'hC3, 1'b0);
    add_byte(8'hE9, 1'b1);

    // random strings, mostly well-formed characters with some noise
    while (pending_bytes.size() < ItemTarget) begin
      nchars = $urandom_range(1, 8);
      for (int c = 0; c < nchars; c++) begin
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
          add_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'hFE, 8'hFF))
                                               : 8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        end else if (kind < 9) begin
          add_byte(8'($urandom), 1'b0);
        end else begin
          pick = $urandom_range(0, 99);
          len  = (pick < 35) ? 1 : (pick < 55) ? 2 : (pick < 70) ? 3 :
                 (pick < 83) ? 4 : (pick < 92) ? 5 : 6;
          // a few sequences are cut short
          keep = (kind < 14 && len > 1) ? $urandom_range(1, len - 1) : len;
          add_byte(rand_lead(len), 1'b0);
          for (int k = 1; k < keep; k++)
            add_byte(($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                  : {2'b10, 6'($urandom)}, 1'b0);
        end
      end
      tail = pending_bytes.pop_back();
      tail.string_end = 1'b1;
      pending_bytes.push_back(tail);
    end
    total_bytes = pending_bytes.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_sent < total_bytes) @(posedge clk_i);
    while (owed_words.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d bytes, checked %0d result words", total_bytes, words_seen);
    $display("ok %0d, invalid lead %0d, truncated %0d, mismatches %0d",
             ok_seen, bad_lead_seen, truncated_seen, mismatches);
    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("timeout with %0d of %0d bytes sent", bytes_sent, total_bytes);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### utf8_stream_decoder.f
sv/u8sd_pkg.sv
sv/u8sd_front.sv
sv/u8sd_queue.sv
sv/u8sd_back.sv
sv/utf8_stream_decoder.sv
dv/tb_top.sv
